FILE: hdl/mspr_pkg.sv
package mspr_pkg;

  // default payload buffer depth
  localparam int MAX_PAYLOAD_DEF = 32;

  // header characters
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_M      = 8'h4D;
  localparam logic [7:0] CHAR_GT     = 8'h3E;

  // result kinds
  localparam logic [1:0] KIND_START   = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_CSUM    = 2'd2;
  localparam logic [1:0] KIND_OVFL    = 2'd3;

  // job handed from the parser to the emitter
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] command;
    logic [7:0] size;
  } job_t;

endpackage

FILE: hdl/mspr_ram.sv
module mspr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: hdl/mspr_job_fifo.sv
module mspr_job_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mspr_pkg::job_t  push_job,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output mspr_pkg::job_t  head
);

  mspr_pkg::job_t slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = slot[rd_ptr];

  // two-entry circular queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // job slots
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_job;
    end
  end

endmodule

FILE: hdl/mspr_front.sv
module mspr_front #(
  parameter int MAX_PAYLOAD = mspr_pkg::MAX_PAYLOAD_DEF,
  parameter int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      rx_byte,
  input  logic            q_full,
  input  logic            run_pending,
  output logic            push,
  output mspr_pkg::job_t  push_job,
  output logic            wr_en,
  output logic [AW-1:0]   wr_addr,
  output logic [7:0]      wr_data
);

  localparam int CW = $clog2(MAX_PAYLOAD + 1);

  typedef enum logic [2:0] {
    PH_HUNT, PH_DOLLAR, PH_GOT_M, PH_SIZE, PH_CMD, PH_PAYLOAD, PH_CHECK
  } phase_t;

  phase_t         phase;
  logic [7:0]     held_size;
  logic [7:0]     held_command;
  logic [CW-1:0]  byte_count;
  logic [7:0]     running_xor;
  logic           take;
  logic [CW-1:0]  count_inc;
  logic           oversize;

  // payload bytes wait while a job is queued or a run still reads the buffer
  assign in_ready  = !q_full && !(phase == PH_PAYLOAD && run_pending);
  assign take      = in_valid && in_ready;
  assign count_inc = byte_count + CW'(1);
  assign oversize  = rx_byte > 8'(MAX_PAYLOAD);

  assign wr_en   = take && (phase == PH_PAYLOAD);
  assign wr_addr = AW'(byte_count);
  assign wr_data = rx_byte;

  // jobs for the emitter: overflow at the size byte, verdict at the checksum
  always_comb begin
    push     = 1'b0;
    push_job = '{kind: mspr_pkg::KIND_START, command: held_command, size: held_size};
    if (take && phase == PH_SIZE && oversize) begin
      push     = 1'b1;
      push_job = '{kind: mspr_pkg::KIND_OVFL, command: 8'd0, size: rx_byte};
    end else if (take && phase == PH_CHECK) begin
      push = 1'b1;
      if (rx_byte != running_xor) begin
        push_job.kind = mspr_pkg::KIND_CSUM;
      end
    end
  end

  // header hunt and frame tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      held_size    <= 8'd0;
      held_command <= 8'd0;
      byte_count   <= '0;
      running_xor  <= 8'd0;
    end else if (take) begin
      unique case (phase)
        PH_DOLLAR: phase <= (rx_byte == mspr_pkg::CHAR_M) ? PH_GOT_M : PH_HUNT;
        PH_GOT_M:  phase <= (rx_byte == mspr_pkg::CHAR_GT) ? PH_SIZE : PH_HUNT;
        PH_SIZE: begin
          held_size <= rx_byte;
          phase     <= oversize ? PH_HUNT : PH_CMD;
        end
        PH_CMD: begin
          held_command <= rx_byte;
          byte_count   <= '0;
          running_xor  <= held_size ^ rx_byte;
          phase        <= (held_size == 8'd0) ? PH_CHECK : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          running_xor <= running_xor ^ rx_byte;
          byte_count  <= count_inc;
          if (8'(count_inc) >= held_size) begin
            phase <= PH_CHECK;
          end
        end
        PH_CHECK: phase <= PH_HUNT;
        default:  phase <= (rx_byte == mspr_pkg::CHAR_DOLLAR) ? PH_DOLLAR : PH_HUNT;
      endcase
    end
  end

endmodule

FILE: hdl/mspr_back.sv
module mspr_back #(
  parameter int MAX_PAYLOAD = mspr_pkg::MAX_PAYLOAD_DEF,
  parameter int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_not_empty,
  input  mspr_pkg::job_t  q_head,
  output logic            pop,
  output logic            busy,
  output logic [AW-1:0]   rd_addr,
  input  logic [7:0]      rd_data,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [1:0]      kind,
  output logic [7:0]      frame_command,
  output logic [7:0]      frame_size,
  output logic [7:0]      payload_byte,
  output logic            last
);

  localparam int CW = $clog2(MAX_PAYLOAD + 1);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_DATA} state_t;

  state_t         state;
  logic [CW-1:0]  idx;
  logic [7:0]     run_command;
  logic [7:0]     run_size;
  logic           out_free;
  logic           idx_last;

  assign out_free = !out_valid || out_ready;
  assign pop      = (state == S_IDLE) && q_not_empty && out_free;
  assign busy     = (state != S_IDLE);
  assign rd_addr  = AW'(idx);
  assign idx_last = (8'(idx) + 8'd1) == run_size;

  // emitter sequence and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            out_valid     <= 1'b1;
            kind          <= q_head.kind;
            frame_command <= q_head.command;
            frame_size    <= q_head.size;
            payload_byte  <= 8'd0;
            run_command   <= q_head.command;
            run_size      <= q_head.size;
            idx           <= '0;
            if (q_head.kind == mspr_pkg::KIND_START && q_head.size != 8'd0) begin
              last  <= 1'b0;
              state <= S_READ;
            end else begin
              last <= 1'b1;
            end
          end
        end
        // registered read: the data lands in the cycle after the address
        S_READ: state <= S_DATA;
        S_DATA: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            kind          <= mspr_pkg::KIND_PAYLOAD;
            frame_command <= run_command;
            frame_size    <= run_size;
            payload_byte  <= rd_data;
            last          <= idx_last;
            if (idx_last) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + CW'(1);
              state <= S_READ;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/msp_response_frame_parser.sv
// Response frame parser: takes one received byte per accepted item, finds the header
// '$' 'M' '>', then size, command, payload and an XOR checksum byte. A good frame yields a
// frame-start item followed by one item per payload byte (tlast on the final one); a bad
// checksum yields one checksum-error item, and a size above MAX_PAYLOAD yields one overflow
// item at the size byte. Header, size, command and checksum bytes are taken one per cycle
// while the two-entry job queue between parser and emitter has room (tready is low while
// it is full); start, error and overflow items leave from the output register once their
// job is popped, and each payload item passes through S_READ and S_DATA, as the buffer
// read is registered and its address moves on only after the previous byte is in the
// output register. While a job is queued or a run is being emitted, the payload bytes of
// the next frame are held off too. The payload buffer needs no clearing after reset.
module msp_response_frame_parser #(
  parameter int MAX_PAYLOAD = mspr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] frame_command, [15:8] frame_size,
                                      // [23:16] payload_byte
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast    // last
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic           q_full;
  logic           q_not_empty;
  logic           push;
  logic           pop;
  logic           busy;
  mspr_pkg::job_t push_job;
  mspr_pkg::job_t q_head;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [7:0]     wr_data;
  logic [AW-1:0]  rd_addr;
  logic [7:0]     rd_data;
  logic [7:0]     frame_command;
  logic [7:0]     frame_size;
  logic [7:0]     payload_byte;

  // parser
  mspr_front #(.MAX_PAYLOAD(MAX_PAYLOAD), .AW(AW)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .rx_byte    (s_axis_tdata),
    .q_full     (q_full),
    .run_pending(q_not_empty || busy),
    .push       (push),
    .push_job   (push_job),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  // payload buffer
  mspr_ram #(.WIDTH(8), .DEPTH(MAX_PAYLOAD), .AW(AW)) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // job queue between parser and emitter
  mspr_job_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .not_empty(q_not_empty),
    .head     (q_head)
  );

  // emitter
  mspr_back #(.MAX_PAYLOAD(MAX_PAYLOAD), .AW(AW)) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_not_empty  (q_not_empty),
    .q_head       (q_head),
    .pop          (pop),
    .busy         (busy),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .kind         (m_axis_tuser),
    .frame_command(frame_command),
    .frame_size   (frame_size),
    .payload_byte (payload_byte),
    .last         (m_axis_tlast)
  );

  assign m_axis_tdata = {payload_byte, frame_size, frame_command};

endmodule

FILE: tb/sv/msp_frame_checker.sv
module msp_frame_checker #(
  parameter int MAX_PAYLOAD = mspr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,
  input  logic [1:0]  m_axis_tuser,
  input  logic        m_axis_tlast,
  output int          fails,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  typedef enum logic [2:0] {
    HUNT_DOLLAR,
    WANT_M,
    WANT_GT,
    WANT_SIZE,
    WANT_CMD,
    TAKE_PAYLOAD,
    WANT_CSUM
  } parse_phase_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] command;
    logic [7:0] length;
    logic [7:0] payload;
    logic       last;
  } frame_item_t;

  // shadow copy of the parser state
  parse_phase_e phase;
  logic [7:0]   frame_len;
  logic [7:0]   frame_cmd;
  logic [5:0]   taken;
  logic [7:0]   csum_acc;
  logic [7:0]   payload_buf [MAX_PAYLOAD];

  frame_item_t  expected_results [$];
  frame_item_t  want;
  frame_item_t  got;
  int           fail_total = 0;

  function automatic frame_item_t make_item(input logic [1:0] kind, input logic [7:0] command,
                                            input logic [7:0] length,
                                            input logic [7:0] payload, input logic last);
    frame_item_t r;
    r.kind    = kind;
    r.command = command;
    r.length  = length;
    r.payload = payload;
    r.last    = last;
    return r;
  endfunction

  // advance the parser by one received byte and queue the items it releases
  task automatic parse_rx_byte(input logic [7:0] b);
    case (phase)
      WANT_M: begin
        phase = (b == mspr_pkg::CHAR_M) ? WANT_GT : HUNT_DOLLAR;
      end
      WANT_GT: begin
        phase = (b == mspr_pkg::CHAR_GT) ? WANT_SIZE : HUNT_DOLLAR;
      end
      WANT_SIZE: begin
        frame_len = b;
        if (int'(b) > MAX_PAYLOAD) begin
          expected_results.push_back(make_item(mspr_pkg::KIND_OVFL, 8'h00, b, 8'h00, 1'b1));
          phase = HUNT_DOLLAR;
        end else begin
          phase = WANT_CMD;
        end
      end
      WANT_CMD: begin
        frame_cmd = b;
        taken     = '0;
        csum_acc  = frame_len ^ b;
        phase     = (frame_len == 8'h00) ? WANT_CSUM : TAKE_PAYLOAD;
      end
      TAKE_PAYLOAD: begin
        if (int'(taken) < MAX_PAYLOAD) payload_buf[BW'(taken)] = b;
        csum_acc = csum_acc ^ b;
        taken    = taken + 6'd1;
        if (int'(taken) >= int'(frame_len) || int'(taken) >= MAX_PAYLOAD) phase = WANT_CSUM;
      end
      WANT_CSUM: begin
        if (b == csum_acc) begin
          expected_results.push_back(make_item(mspr_pkg::KIND_START, frame_cmd, frame_len,
                                               8'h00, frame_len == 8'h00));
          for (int i = 0; i < int'(frame_len) && i < MAX_PAYLOAD; i++)
            expected_results.push_back(make_item(mspr_pkg::KIND_PAYLOAD, frame_cmd, frame_len,
                                                 payload_buf[BW'(i)],
                                                 i + 1 == int'(frame_len)));
        end else begin
          expected_results.push_back(make_item(mspr_pkg::KIND_CSUM, frame_cmd, frame_len,
                                               8'h00, 1'b1));
        end
        phase = HUNT_DOLLAR;
      end
      default: begin
        phase = (b == mspr_pkg::CHAR_DOLLAR) ? WANT_M : HUNT_DOLLAR;
      end
    endcase
  endtask

  task automatic check_field(input string what, input logic [7:0] exp_val,
                             input logic [7:0] act_val);
    if (act_val !== exp_val) begin
      fail_total++;
      $display("%0t ns: %s mismatch, expected %02h, actual %02h", $time, what, exp_val, act_val);
    end
  endtask

  // predict on accepted input items, compare on accepted output items
  always @(posedge clk) begin
    if (rst) begin
      phase     = HUNT_DOLLAR;
      frame_len = '0;
      frame_cmd = '0;
      taken     = '0;
      csum_acc  = '0;
      expected_results.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) parse_rx_byte(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        got = make_item(m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[15:8],
                        m_axis_tdata[23:16], m_axis_tlast);
        if (expected_results.size() == 0) begin
          fail_total++;
          $display("%0t ns: unexpected item, expected none, actual kind %0d cmd %02h len %02h",
                   $time, got.kind, got.command, got.length);
        end else begin
          want = expected_results.pop_front();
          check_field("kind", 8'(want.kind), 8'(got.kind));
          check_field("frame_command", want.command, got.command);
          check_field("frame_size", want.length, got.length);
          check_field("payload_byte", want.payload, got.payload);
          check_field("last", 8'(want.last), 8'(got.last));
        end
      end
    end
    pending <= expected_results.size();
    fails   <= fail_total;
  end

endmodule

FILE: tb/sv/msp_response_frame_parser_tb.sv
module msp_response_frame_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS_END = 310;
  localparam int CYCLE_LIMIT      = 200000;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  int          fails;
  int          pending;
  int          cycle_count   = 0;
  int          sent_items    = 0;
  int          burst_left    = 0;
  logic [7:0]  stall_tick    = 8'h00;
  logic [1:0]  stall_mode    = 2'd0;

  always #1 clk = ~clk;

  msp_response_frame_parser DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  msp_frame_checker checker_inst (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .fails         (fails),
    .pending       (pending)
  );

  // receiver backpressure, picking a new random pattern whenever stall_tick[5:0] is zero
  always @(posedge clk) begin
    stall_tick <= stall_tick + 8'd1;
    if (stall_tick[5:0] == 6'd0) stall_mode <= 2'($urandom_range(0, 3));
    case (stall_mode)
      2'd0: m_axis_tready <= 1'b1;
      2'd1: m_axis_tready <= ($urandom_range(0, 9) < 7);
      2'd2: m_axis_tready <= (stall_tick[1:0] == 2'b00);
      default: m_axis_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("msp_response_frame_parser test failed");
      $finish;
    end
  end

  // one byte over the input channel, in bursts with random gaps between them
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    burst_left--;
    sent_items++;
  endtask

  // hold the input off until every predicted item has come out
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic send_header();
    send_byte(mspr_pkg::CHAR_DOLLAR);
    send_byte(mspr_pkg::CHAR_M);
    send_byte(mspr_pkg::CHAR_GT);
  endtask

  // header, size, then (if len fits the buffer) command, the first keep payload bytes, and the checksum if complete
  task automatic send_frame(input int unsigned len, input logic [7:0] cmd, input bit corrupt,
                            input int unsigned keep);
    logic [7:0] csum;
    logic [7:0] b;
    send_header();
    send_byte(8'(len));
    if (len > mspr_pkg::MAX_PAYLOAD_DEF) return;
    send_byte(cmd);
    csum = 8'(len) ^ cmd;
    for (int unsigned i = 0; i < keep; i++) begin
      b = 8'($urandom);
      csum = csum ^ b;
      send_byte(b);
    end
    if (keep < len) return;
    if (corrupt) csum = csum ^ 8'($urandom_range(1, 255));
    send_byte(csum);
  endtask

  initial begin
    int          pick;
    int unsigned len;
    int          next_pause;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero length frame with all-ones command
    send_header();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hFF);
    // second dollar sign where 'M' belongs breaks the header
    send_byte(mspr_pkg::CHAR_DOLLAR);
    send_byte(mspr_pkg::CHAR_DOLLAR);
    send_byte(mspr_pkg::CHAR_M);
    send_byte(mspr_pkg::CHAR_GT);
    // sizes just above the buffer and at the top of the range
    send_header();
    send_byte(8'(mspr_pkg::MAX_PAYLOAD_DEF + 1));
    send_header();
    send_byte(8'hFF);
    // one byte frame with a bad checksum (good one would be fe)
    send_header();
    send_byte(8'h01);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h00);
    drain_results();

    // random traffic, mostly well formed frames
    next_pause = 100;
    while (sent_items < RANDOM_ITEMS_END) begin
      if (sent_items >= next_pause) begin
        drain_results();
        next_pause += 100;
      end
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        pick = $urandom_range(0, 99);
        if (pick < 50)      len = $urandom_range(0, 4);
        else if (pick < 75) len = $urandom_range(5, 12);
        else if (pick < 90) len = $urandom_range(13, mspr_pkg::MAX_PAYLOAD_DEF - 1);
        else                len = mspr_pkg::MAX_PAYLOAD_DEF;
        send_frame(len, 8'($urandom), $urandom_range(0, 99) < 15, len);
      end else if (pick < 80) begin
        send_frame($urandom_range(mspr_pkg::MAX_PAYLOAD_DEF + 1, 255), 8'h00, 1'b0, 0);
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 4))
          send_byte(($urandom_range(0, 3) == 0) ? mspr_pkg::CHAR_DOLLAR : 8'($urandom));
      end else if (pick < 95) begin
        send_byte(mspr_pkg::CHAR_DOLLAR);
        if ($urandom_range(0, 1) == 1) send_byte(mspr_pkg::CHAR_M);
        send_byte(8'($urandom));
      end else begin
        // frame cut short; the next bytes are taken as its payload
        len = $urandom_range(1, 16);
        send_frame(len, 8'($urandom), 1'b0, $urandom_range(0, len - 1));
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("msp_response_frame_parser test passed");
    end else begin
      $display("msp_response_frame_parser test failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/mspr_pkg.sv
hdl/mspr_ram.sv
hdl/mspr_job_fifo.sv
hdl/mspr_front.sv
hdl/mspr_back.sv
hdl/msp_response_frame_parser.sv
tb/sv/msp_frame_checker.sv
tb/sv/msp_response_frame_parser_tb.sv
